// ===== rtl/core/recent_history_ring_match_top_assert.svh =====
// Assertion macros for the recent-history ring match block.
// Included by recent_history_ring_match_top; no other dependencies.
`ifndef RECENT_HISTORY_RING_MATCH_TOP_ASSERT_SVH
`define RECENT_HISTORY_RING_MATCH_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RHRM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RHRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RHRM_ASSERT_SAME(lbl, ante, cons, msg)
`define RHRM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rhrm_pkg.sv =====
// Shared types and constants for the recent-history ring match block.
// No dependencies.
package rhrm_pkg;

  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_PUSH  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/recent_history_ring_match_top.sv =====
// Recent-history ring with membership lookup: ring memory, walk sequencer, output register.
// Depends on rhrm_pkg and recent_history_ring_match_top_assert.svh.
//
// Usage: one slave stream of items, one master stream of results, one result per item.
// s_tuser selects push (1) or query (0). A push stores the index in the ring at the
// write pointer; a query compares the index against the newest min(check_count, fill)
// entries, newest first, one entry per cycle through a single comparator fed by the
// registered read port of the ring memory.
// Timing: a push completes at its transfer; its result is valid the next cycle.
// A query walks its examined entries and then takes the finish step, leaving the walk
// early on a hit; one that examines nothing goes straight to the finish step. The
// result is valid the cycle after the finish step. The walk over the ring memory
// sets the time a query takes; pushes skip the walk, one per cycle while results drain.
// One item is in flight at a time; s_tready is high only while the sequencer is idle
// and the output register is empty or being drained.
// A stalled receiver holds the result in the output register and the block waits.
// Reset clears pointer, fill count and sequencer; the ring memory is not cleared and
// entries beyond the fill count are never compared.
`include "recent_history_ring_match_top_assert.svh"

module recent_history_ring_match_top
  import rhrm_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] index_value, [23:16] check_count
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [0] hit, [16:1] newest_entry, [23:17] zero
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_FILL = CW'(DEPTH);

  logic [15:0]   ring [0:DEPTH-1];
  logic [15:0]   rd_data;
  logic [AW-1:0] rd_addr, rd_addr_next;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] fill;
  logic [CW-1:0] remain;
  logic          pend;
  logic          hit;
  logic [15:0]   idx;
  logic [15:0]   newest;
  logic          out_hit;
  logic [15:0]   out_newest;
  state_t        state, state_next;

  logic          in_xfer;
  logic          out_free;
  logic          is_push;
  logic          hit_now;
  logic          issue;
  logic          finish;
  logic [7:0]    fill_ext;
  logic [CW-1:0] clamp_count;
  logic [AW-1:0] newest_slot;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign is_push  = (s_tuser == KIND_PUSH);
  assign fill_ext = 8'(fill);
  assign clamp_count = (s_tdata[23:16] > fill_ext) ? fill : CW'(s_tdata[23:16]);
  assign newest_slot = (wr_ptr == '0) ? LAST_SLOT : wr_ptr - 1'b1;
  assign rd_addr_next = (rd_addr == '0) ? LAST_SLOT : rd_addr - 1'b1;
  assign hit_now = pend && (rd_data == idx);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && !is_push) begin
          state_next = (clamp_count == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit_now || (remain == '0 && !pend)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    finish   = 1'b0;
    case (state)
      ST_IDLE: s_tready = out_free;
      ST_WALK: issue    = !hit_now && (remain != '0);
      ST_DONE: finish   = out_free;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer && is_push) begin
      ring[wr_ptr] <= s_tdata[15:0];
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr_ptr   <= '0;
      fill     <= '0;
      newest   <= EMPTY_MARK;
      m_tvalid <= 1'b0;
      pend     <= 1'b0;
      hit      <= 1'b0;
    end else begin
      state <= state_next;
      if ((in_xfer && is_push) || finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_xfer) begin
        idx <= s_tdata[15:0];
        hit <= 1'b0;
        pend <= 1'b0;
        if (is_push) begin
          wr_ptr     <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
          fill       <= (fill == FULL_FILL) ? fill : fill + 1'b1;
          newest     <= s_tdata[15:0];
          out_hit    <= 1'b0;
          out_newest <= s_tdata[15:0];
        end else begin
          remain  <= clamp_count;
          rd_addr <= newest_slot;
        end
      end
      if (state == ST_WALK) begin
        if (hit_now) begin
          hit  <= 1'b1;
          pend <= 1'b0;
        end else begin
          pend <= issue;
          if (issue) begin
            remain  <= remain - 1'b1;
            rd_addr <= rd_addr_next;
          end
        end
      end
      if (finish) begin
        out_hit    <= hit;
        out_newest <= newest;
      end
    end
  end

  assign m_tdata = {7'b0, out_newest, out_hit};

  `RHRM_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FULL_FILL, "fill count above depth")
  `RHRM_ASSERT_NEXT(a_push_result, in_xfer && is_push, m_tvalid && out_newest == $past(s_tdata[15:0]) && !out_hit, "push result wrong")
  `RHRM_ASSERT_NEXT(a_hit_ends_walk, state == ST_WALK && hit_now, state == ST_DONE && hit, "hit did not end walk")
  `RHRM_ASSERT_SAME(a_busy_not_ready, state != ST_IDLE, !s_tready, "ready while busy")

endmodule
